[src/shift_add_cost_table_assert.svh]
`ifndef SHIFT_ADD_COST_TABLE_ASSERT_SVH
`define SHIFT_ADD_COST_TABLE_ASSERT_SVH
// Assertion helpers: implication checked on every rising edge outside reset.
`define SACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SACT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/sact_pkg.sv]
package sact_pkg;
  localparam int unsigned TableDepth = 65536;
  localparam logic [6:0] UnknownCost = 7'd127;
  localparam logic [6:0] MaxLevel = 7'd126;

  typedef enum logic [1:0] {
    FuncInit = 2'd0,
    FuncCompute = 2'd1,
    FuncRead = 2'd2,
    FuncNone = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StNoWork = 2'd1,
    StRange = 2'd2
  } status_e;

  localparam logic [0:0] RegTop = 1'b0;
  localparam logic [0:0] RegLimit = 1'b1;
endpackage

[src/sact_ram.sv]
module sact_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/shift_add_cost_table.sv]
// Channel   | Dir | Transaction payload (lowest bit first)
// s_axis    | in  | tdata[1:0] func, [17:2] index, [23:18] zero (24 bits)
// m_axis    | out | tdata[6:0] cost, [13:7] level, [29:14] smallest_new,
//           |     |   [46:30] remaining, [48:47] status, [55:49] zero
// apb       | cfg | 0x0 top_index, 0x4 level_limit; pready tied high
// Reset: control registers set to top_index 0xFFFF and level_limit 127; the cost memory
// is swept to unknown, one entry a cycle, before s_axis_tready first rises.
// Func 3 and compute without work answer without a memory access; init rewrites
// the whole memory.
// Compute: steps through each entry a, each pair b>=a for a of lower cost, each candidate
// (up to 3), then each entry v and each shifted value.
// Stalls: one command at a time; a new command is taken while the previous result
// waits in the output register, and its own result waits in SResp.
module shift_add_cost_table #(
  parameter int unsigned TABLE_DEPTH = sact_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [1:0] func, [17:2] index, [23:18] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] cost, [13:7] level, [29:14] smallest_new, [46:30] remaining,
  // [48:47] status, [55:49] zero
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sact_pkg::*;
  `include "shift_add_cost_table_assert.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    SClr, SIdle, SInit, SRdWait, SRdOut,
    SPairRdA, SPairA, SPairRdB, SPairB, SCandRd, SCandChk,
    SShRdV, SShV, SShRd, SShChk, SFin, SResp
  } state_e;

  state_e state_q;
  logic [15:0] top_q, idx_q;
  logic [6:0] limit_q, lvl_q, c_q, costa_q;
  logic [16:0] unk_q;
  logic [AW-1:0] m_q, a_q, b_q, v_q, n_q, sum_q, diff_q, prod_q, newmin_q;
  logic [2:0] cand_q;  // pending candidates: sum, difference, product
  logic found_q;
  logic [55:0] res_q, out_q;
  logic ovalid_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [6:0] wdata, rdata;

  sact_ram #(.Width(7), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLimit) ? {25'd0, limit_q} : {16'd0, top_q};

  // top index clipped to the table
  logic [AW-1:0] eff_m;
  assign eff_m = (32'(top_q) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1) : AW'(top_q);

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = out_q;

  logic out_free, out_load;
  assign out_free = !ovalid_q || m_axis_tready;
  assign out_load = (state_q == SResp) && out_free;

  logic no_work;
  assign no_work = (unk_q == '0) || (lvl_q >= MaxLevel) ||
                   (limit_q != 7'd127 && lvl_q + 7'd1 > limit_q);

  // init sweep: entry 0 and powers of two up to M get cost 0
  logic a_pow;
  assign a_pow = ((a_q & (a_q - AW'(1))) == '0) && (a_q <= m_q);

  // pair checks on (a, b), b >= a; rdata holds cost(b) in SPairB
  logic [AW:0] pair_sum;
  logic [2*AW-1:0] pair_prod;
  logic [7:0] cost_sum, c_m1;
  logic sum_ok, diff_ok, prod_ok;
  assign pair_sum = {1'b0, a_q} + {1'b0, b_q};
  assign pair_prod = a_q * b_q;
  assign cost_sum = {1'b0, costa_q} + {1'b0, rdata};
  assign c_m1 = {1'b0, c_q} - 8'd1;
  assign diff_ok = (cost_sum == c_m1);
  assign sum_ok = diff_ok && (pair_sum <= {1'b0, m_q});
  assign prod_ok = (costa_q != '0) && (rdata != '0) && (cost_sum == {1'b0, c_q}) &&
                   (pair_prod <= (2*AW)'(m_q));

  logic [AW-1:0] cand_addr;
  logic [2:0] cand_rest;
  assign cand_addr = cand_q[0] ? sum_q : (cand_q[1] ? diff_q : prod_q);
  assign cand_rest = cand_q & (cand_q - 3'd1);

  logic v_dbl_ok, n_dbl_ok;
  assign v_dbl_ok = ({v_q, 1'b0} <= {1'b0, m_q});
  assign n_dbl_ok = ({n_q, 1'b0} <= {1'b0, m_q});

  state_e shift_start;
  assign shift_start = (m_q == '0) ? SFin : SShRdV;

  logic [15:0] new_small;
  assign new_small = found_q ? 16'(newmin_q) : 16'd0;

  // memory port: one access per state; a write is never followed by a read
  // of the same entry in the same cycle
  always_comb begin
    we = 1'b0; waddr = a_q; wdata = UnknownCost; raddr = a_q;
    unique case (state_q)
      SClr: we = 1'b1;
      SInit: begin
        we = 1'b1;
        wdata = a_pow ? 7'd0 : UnknownCost;
      end
      SRdWait: raddr = AW'(idx_q);
      SPairRdB: raddr = b_q;
      SCandRd: raddr = cand_addr;
      SCandChk: begin
        we = (rdata == UnknownCost); waddr = cand_addr; wdata = c_q;
      end
      SShRdV: raddr = v_q;
      SShRd: raddr = n_q;
      SShChk: begin
        we = (rdata == UnknownCost); waddr = n_q; wdata = c_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; top_q <= 16'hFFFF; limit_q <= 7'd127; lvl_q <= '0;
      unk_q <= '0; c_q <= '0; m_q <= '0; a_q <= '0; b_q <= '0; v_q <= '0;
      n_q <= '0; costa_q <= '0; cand_q <= '0; sum_q <= '0; diff_q <= '0;
      prod_q <= '0; found_q <= 1'b0; newmin_q <= '0; idx_q <= '0;
      res_q <= '0; out_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegTop) top_q <= pwdata[15:0];
        else limit_q <= pwdata[6:0];
      end
      if (out_load) begin
        out_q <= res_q; ovalid_q <= 1'b1;
      end else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        SClr: begin
          if (a_q == AW'(TABLE_DEPTH - 1)) begin a_q <= '0; state_q <= SIdle; end
          else a_q <= a_q + AW'(1);
        end
        SIdle: begin
          if (s_axis_tvalid) begin
            m_q <= eff_m;
            idx_q <= s_axis_tdata[17:2];
            unique case (func_e'(s_axis_tdata[1:0]))
              FuncInit: begin
                a_q <= '0; c_q <= '0; unk_q <= 17'(eff_m); found_q <= 1'b0;
                newmin_q <= '0; state_q <= SInit;
              end
              FuncCompute: begin
                if (no_work) begin
                  res_q <= {7'd0, StNoWork, unk_q, 16'd0, lvl_q, 7'd0};
                  state_q <= SResp;
                end else begin
                  c_q <= lvl_q + 7'd1; a_q <= '0; found_q <= 1'b0;
                  newmin_q <= '0; state_q <= SPairRdA;
                end
              end
              FuncRead: state_q <= SRdWait;
              FuncNone: begin
                res_q <= {7'd0, StNoWork, unk_q, 16'd0, lvl_q, 7'd0};
                state_q <= SResp;
              end
            endcase
          end
        end
        SInit: begin
          if (a_q != '0 && a_pow) unk_q <= unk_q - 17'd1;
          if (a_q == AW'(TABLE_DEPTH - 1)) state_q <= SFin;
          else a_q <= a_q + AW'(1);
        end
        SRdWait: state_q <= SRdOut;
        SRdOut: begin
          if (32'(idx_q) > 32'(m_q)) res_q <= {7'd0, StRange, unk_q, 16'd0, lvl_q, 7'd0};
          else res_q <= {7'd0, StDone, unk_q, 16'd0, lvl_q, rdata};
          state_q <= SResp;
        end
        SPairRdA: state_q <= SPairA;
        SPairA: begin
          // entries of cost c or unknown pair with nothing
          costa_q <= rdata;
          if (rdata < c_q) begin b_q <= a_q; state_q <= SPairRdB; end
          else if (a_q != m_q) begin a_q <= a_q + AW'(1); state_q <= SPairRdA; end
          else begin v_q <= AW'(1); state_q <= shift_start; end
        end
        SPairRdB: state_q <= SPairB;
        SPairB: begin
          cand_q <= {prod_ok, diff_ok, sum_ok};
          sum_q <= pair_sum[AW-1:0];
          diff_q <= b_q - a_q;
          prod_q <= pair_prod[AW-1:0];
          if (sum_ok || diff_ok || prod_ok) state_q <= SCandRd;
          else if (b_q != m_q) begin b_q <= b_q + AW'(1); state_q <= SPairRdB; end
          else if (a_q != m_q) begin a_q <= a_q + AW'(1); state_q <= SPairRdA; end
          else begin v_q <= AW'(1); state_q <= shift_start; end
        end
        SCandRd: state_q <= SCandChk;
        SCandChk: begin
          if (rdata == UnknownCost) begin
            if (!found_q || cand_addr < newmin_q) newmin_q <= cand_addr;
            found_q <= 1'b1;
            if (unk_q != '0) unk_q <= unk_q - 17'd1;
          end
          cand_q <= cand_rest;
          if (cand_rest != '0) state_q <= SCandRd;
          else if (b_q != m_q) begin b_q <= b_q + AW'(1); state_q <= SPairRdB; end
          else if (a_q != m_q) begin a_q <= a_q + AW'(1); state_q <= SPairRdA; end
          else begin v_q <= AW'(1); state_q <= shift_start; end
        end
        SShRdV: state_q <= SShV;
        SShV: begin
          if (rdata == c_q && v_dbl_ok) begin n_q <= v_q << 1; state_q <= SShRd; end
          else if (v_q != m_q) begin v_q <= v_q + AW'(1); state_q <= SShRdV; end
          else state_q <= SFin;
        end
        SShRd: state_q <= SShChk;
        SShChk: begin
          // the chain runs on through entries that are already known
          if (rdata == UnknownCost) begin
            if (!found_q || n_q < newmin_q) newmin_q <= n_q;
            found_q <= 1'b1;
            if (unk_q != '0) unk_q <= unk_q - 17'd1;
          end
          if (n_dbl_ok) begin n_q <= n_q << 1; state_q <= SShRd; end
          else if (v_q != m_q) begin v_q <= v_q + AW'(1); state_q <= SShRdV; end
          else state_q <= SFin;
        end
        SFin: begin
          // end of init (c_q is 0) or of a compute
          lvl_q <= c_q;
          res_q <= {7'd0, StDone, unk_q, new_small, c_q, 7'd0};
          state_q <= SResp;
        end
        SResp: begin
          if (out_free) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `SACT_ASSERT_IMP(a_no_accept_busy, state_q != SIdle, !s_axis_tready, "accept while busy")
  `SACT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data moved")
  `SACT_ASSERT_NEXT(a_keep, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `SACT_ASSERT_IMP(a_lvl, 1'b1, lvl_q <= MaxLevel, "level beyond maximum")
endmodule
